@@ hw/rtl/p2r_pkg.sv @@
// Shared types, constants and a helper function for the pixel to RGBA converter.
package p2r_pkg;

  localparam int ByteW = 8;
  localparam int FmtW  = 3;
  localparam int OffW  = 9;
  localparam int CoefW = 11;
  localparam int SumW  = 20;

  typedef enum logic [FmtW-1:0] {
    FmtRgba8888 = 3'd0,
    FmtRgbx8888 = 3'd1,
    FmtRgb888   = 3'd2,
    FmtRgb565   = 3'd3,
    FmtYcbcr    = 3'd4
  } pix_fmt_t;

  localparam logic signed [CoefW-1:0] CoefY  = 11'sd298;
  localparam logic signed [CoefW-1:0] CoefRv = 11'sd409;
  localparam logic signed [CoefW-1:0] CoefGu = 11'sd100;
  localparam logic signed [CoefW-1:0] CoefGv = 11'sd208;
  localparam logic signed [CoefW-1:0] CoefBu = 11'sd516;

  localparam logic signed [OffW-1:0] LumaOffset   = 9'sd16;
  localparam logic signed [OffW-1:0] ChromaOffset = 9'sd128;
  localparam logic signed [SumW-1:0] RoundBias    = 20'sd128;
  localparam logic [ByteW-1:0]       ByteMax      = 8'hff;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [ByteW-1:0] sat_shift(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    sh = s >>> 8;
    if (sh < 0) begin
      sat_shift = '0;
    end else if (sh > $signed({{(SumW-ByteW){1'b0}}, ByteMax})) begin
      sat_shift = ByteMax;
    end else begin
      sat_shift = sh[ByteW-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/p2r_if.sv @@
// Valid/ready channel interfaces for pixels, results and the format register write.
interface p2r_in_if;
  logic                     valid;
  logic                     ready;
  logic [p2r_pkg::ByteW-1:0] raw_byte0;
  logic [p2r_pkg::ByteW-1:0] raw_byte1;
  logic [p2r_pkg::ByteW-1:0] raw_byte2;
  logic [p2r_pkg::ByteW-1:0] raw_byte3;
  logic [p2r_pkg::ByteW-1:0] luma_sample;
  logic [p2r_pkg::ByteW-1:0] blue_chroma;
  logic [p2r_pkg::ByteW-1:0] red_chroma;

  modport source (output valid, raw_byte0, raw_byte1, raw_byte2, raw_byte3,
                  luma_sample, blue_chroma, red_chroma, input ready);
  modport sink (input valid, raw_byte0, raw_byte1, raw_byte2, raw_byte3,
                luma_sample, blue_chroma, red_chroma, output ready);
endinterface

interface p2r_out_if;
  logic                     valid;
  logic                     ready;
  logic [p2r_pkg::ByteW-1:0] red;
  logic [p2r_pkg::ByteW-1:0] green;
  logic [p2r_pkg::ByteW-1:0] blue;
  logic [p2r_pkg::ByteW-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface p2r_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [p2r_pkg::FmtW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/p2r_ycc_math.sv @@
// Three-stage BT.601 YCbCr to RGB arithmetic with a combinational clamp at the end.
module p2r_ycc_math (
  input  logic                      clk,
  input  p2r_pkg::stage_en_t        en,
  input  logic [p2r_pkg::ByteW-1:0] luma,
  input  logic [p2r_pkg::ByteW-1:0] cb,
  input  logic [p2r_pkg::ByteW-1:0] cr,
  output logic [p2r_pkg::ByteW-1:0] red,
  output logic [p2r_pkg::ByteW-1:0] green,
  output logic [p2r_pkg::ByteW-1:0] blue
);

  localparam int OffW = p2r_pkg::OffW;
  localparam int SumW = p2r_pkg::SumW;

  logic signed [OffW-1:0] y_off_r, u_off_r, v_off_r;
  logic signed [OffW-1:0] y_off_nxt, u_off_nxt, v_off_nxt;
  logic signed [SumW-1:0] c_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [SumW-1:0] c_nxt, rv_nxt, gu_nxt, gv_nxt, bu_nxt;
  logic signed [SumW-1:0] r_sum_r, g_sum_r, b_sum_r;
  logic signed [SumW-1:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;

  assign y_off_nxt = $signed({1'b0, luma}) - p2r_pkg::LumaOffset;
  assign u_off_nxt = $signed({1'b0, cb}) - p2r_pkg::ChromaOffset;
  assign v_off_nxt = $signed({1'b0, cr}) - p2r_pkg::ChromaOffset;

  assign c_nxt  = SumW'(y_off_r) * SumW'(p2r_pkg::CoefY);
  assign rv_nxt = SumW'(v_off_r) * SumW'(p2r_pkg::CoefRv);
  assign gu_nxt = SumW'(u_off_r) * SumW'(p2r_pkg::CoefGu);
  assign gv_nxt = SumW'(v_off_r) * SumW'(p2r_pkg::CoefGv);
  assign bu_nxt = SumW'(u_off_r) * SumW'(p2r_pkg::CoefBu);

  assign r_sum_nxt = c_r + rv_r + p2r_pkg::RoundBias;
  assign g_sum_nxt = c_r - gu_r - gv_r + p2r_pkg::RoundBias;
  assign b_sum_nxt = c_r + bu_r + p2r_pkg::RoundBias;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y_off_r <= y_off_nxt;
      u_off_r <= u_off_nxt;
      v_off_r <= v_off_nxt;
    end
    if (en.s2) begin
      c_r  <= c_nxt;
      rv_r <= rv_nxt;
      gu_r <= gu_nxt;
      gv_r <= gv_nxt;
      bu_r <= bu_nxt;
    end
    if (en.s3) begin
      r_sum_r <= r_sum_nxt;
      g_sum_r <= g_sum_nxt;
      b_sum_r <= b_sum_nxt;
    end
  end

  assign red   = p2r_pkg::sat_shift(r_sum_r);
  assign green = p2r_pkg::sat_shift(g_sum_r);
  assign blue  = p2r_pkg::sat_shift(b_sum_r);

endmodule

@@ hw/rtl/p2r_direct_path.sv @@
// Decode of the byte-oriented formats, delayed to line up with the YCbCr arithmetic.
module p2r_direct_path (
  input  logic                      clk,
  input  p2r_pkg::stage_en_t        en,
  input  p2r_pkg::pix_fmt_t         fmt,
  input  logic [p2r_pkg::ByteW-1:0] byte0,
  input  logic [p2r_pkg::ByteW-1:0] byte1,
  input  logic [p2r_pkg::ByteW-1:0] byte2,
  input  logic [p2r_pkg::ByteW-1:0] byte3,
  output logic [p2r_pkg::ByteW-1:0] red,
  output logic [p2r_pkg::ByteW-1:0] green,
  output logic [p2r_pkg::ByteW-1:0] blue,
  output logic [p2r_pkg::ByteW-1:0] alpha,
  output logic                      sel_ycc
);

  localparam int PixW = 4 * p2r_pkg::ByteW + 1;

  logic [PixW-1:0] s1_r, s2_r, s3_r;
  logic [PixW-1:0] s1_nxt;

  always_comb begin
    case (fmt)
      p2r_pkg::FmtRgba8888: begin
        s1_nxt = {1'b0, byte0, byte1, byte2, byte3};
      end
      p2r_pkg::FmtRgbx8888, p2r_pkg::FmtRgb888: begin
        s1_nxt = {1'b0, byte0, byte1, byte2, p2r_pkg::ByteMax};
      end
      p2r_pkg::FmtRgb565: begin
        s1_nxt = {1'b0,
                  byte1[7:3], byte1[7:5],
                  byte1[2:0], byte0[7:5], byte1[2:1],
                  byte0[4:0], byte0[4:2],
                  p2r_pkg::ByteMax};
      end
      p2r_pkg::FmtYcbcr: begin
        s1_nxt = {1'b1, {(3 * p2r_pkg::ByteW){1'b0}}, p2r_pkg::ByteMax};
      end
      default: begin
        s1_nxt = {1'b0, {(3 * p2r_pkg::ByteW){1'b0}}, p2r_pkg::ByteMax};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_r <= s1_nxt;
    end
    if (en.s2) begin
      s2_r <= s1_r;
    end
    if (en.s3) begin
      s3_r <= s2_r;
    end
  end

  assign {sel_ycc, red, green, blue, alpha} = s3_r;

endmodule

@@ hw/rtl/pixel_to_rgba_converter.sv @@
// Top level of the pixel to RGBA converter: stage control, format register and result register.
//
//   channel   direction  carries
//   in_pix    sink       raw_byte0..3, luma_sample, blue_chroma, red_chroma
//   out_pix   source     red, green, blue, alpha
//   cfg_wr    sink       data (pixel_format), always ready
//
// One item per cycle is accepted unless every stage is full and the output is stalled.
// Stages follow the YCbCr path: offsets, products, sums, then clamp into the result register.
// Reset clears the stage valid bits and sets the format to RGBA8888.
// A full stage holds while the stage after it is full and stalled, so bubbles are filled first.
module pixel_to_rgba_converter (
  input  logic     clk,
  input  logic     rst_n,
  p2r_in_if.sink   in_pix,
  p2r_out_if.source out_pix,
  p2r_cfg_if.sink  cfg_wr
);

  localparam int ByteW = p2r_pkg::ByteW;

  p2r_pkg::pix_fmt_t  fmt_r;
  p2r_pkg::stage_en_t en;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ready1, ready2, ready3, ready_out;
  logic [ByteW-1:0] ycc_red, ycc_green, ycc_blue;
  logic [ByteW-1:0] dir_red, dir_green, dir_blue, dir_alpha;
  logic             sel_ycc;
  logic [ByteW-1:0] red_r, green_r, blue_r, alpha_r;
  logic [ByteW-1:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;

  assign ready_out = !out_valid_r || out_pix.ready;
  assign ready3    = !v3_r || ready_out;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;

  assign en.s1 = ready1;
  assign en.s2 = ready2;
  assign en.s3 = ready3;

  assign in_pix.ready = ready1;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= p2r_pkg::FmtRgba8888;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        fmt_r <= p2r_pkg::pix_fmt_t'(cfg_wr.data);
      end
      if (ready1) begin
        v1_r <= in_pix.valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
      if (ready_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  p2r_ycc_math u_ycc (
    .clk   (clk),
    .en    (en),
    .luma  (in_pix.luma_sample),
    .cb    (in_pix.blue_chroma),
    .cr    (in_pix.red_chroma),
    .red   (ycc_red),
    .green (ycc_green),
    .blue  (ycc_blue)
  );

  p2r_direct_path u_direct (
    .clk     (clk),
    .en      (en),
    .fmt     (fmt_r),
    .byte0   (in_pix.raw_byte0),
    .byte1   (in_pix.raw_byte1),
    .byte2   (in_pix.raw_byte2),
    .byte3   (in_pix.raw_byte3),
    .red     (dir_red),
    .green   (dir_green),
    .blue    (dir_blue),
    .alpha   (dir_alpha),
    .sel_ycc (sel_ycc)
  );

  assign red_nxt   = sel_ycc ? ycc_red   : dir_red;
  assign green_nxt = sel_ycc ? ycc_green : dir_green;
  assign blue_nxt  = sel_ycc ? ycc_blue  : dir_blue;
  assign alpha_nxt = dir_alpha;

  always_ff @(posedge clk) begin
    if (ready_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_pix.valid = out_valid_r;
  assign out_pix.red   = red_r;
  assign out_pix.green = green_r;
  assign out_pix.blue  = blue_r;
  assign out_pix.alpha = alpha_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !out_valid_r)
    else $error("Stage valid bits survived reset.");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> v1_r)
    else $error("Accepted item did not enter the first stage.");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && out_valid_r && !out_pix.ready |-> !in_pix.ready)
    else $error("Input accepted while every stage was full and stalled.");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && out_valid_r && !out_pix.ready |=> v3_r)
    else $error("Third-stage item lost during an output stall.");
`endif

endmodule
